/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, skipped while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/ces_pkg.sv */
package ces_pkg;

  localparam logic [15:0] EpochYear   = 16'd1970;
  // Leap years in years 1 through 1969.
  localparam logic [24:0] LeapsBefore = 25'd477;
  // ceil(2^17 / 25): exact floor(m / 25) for any 14-bit m.
  localparam logic [12:0] Recip25     = 13'd5243;
  localparam int          Recip25Sh   = 17;

  typedef struct packed {
    logic load;
    logic div_prev;
    logic div_cur;
    logic days;
    logic hour;
    logic minute;
    logic second;
  } ces_cmd_t;

  // Days before the start of a month in a common year; months past
  // December count the whole year.
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    case (m) inside
      [4'd0:4'd1]:  d = 9'd0;
      4'd2:         d = 9'd31;
      4'd3:         d = 9'd59;
      4'd4:         d = 9'd90;
      4'd5:         d = 9'd120;
      4'd6:         d = 9'd151;
      4'd7:         d = 9'd181;
      4'd8:         d = 9'd212;
      4'd9:         d = 9'd243;
      4'd10:        d = 9'd273;
      4'd11:        d = 9'd304;
      4'd12:        d = 9'd334;
      default:      d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

/* rtl/ces_ctrl.sv */
`include "assert_macros.svh"

module ces_ctrl
  import ces_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output ces_cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE, DIVA, DIVB, DAYS, HOUR, MINS, SECS
  } state_t;

  state_t   state;
  ces_cmd_t step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
      step  <= '0;
    end else begin
      step <= '0;
      case (state)
        IDLE: begin
          if (start) begin
            state         <= DIVA;
            busy          <= 1'b1;
            step.div_prev <= 1'b1;
          end
        end
        DIVA: begin
          state        <= DIVB;
          step.div_cur <= 1'b1;
        end
        DIVB: begin
          state     <= DAYS;
          step.days <= 1'b1;
        end
        DAYS: begin
          state     <= HOUR;
          step.hour <= 1'b1;
        end
        HOUR: begin
          state       <= MINS;
          step.minute <= 1'b1;
        end
        MINS: begin
          state       <= SECS;
          step.second <= 1'b1;
        end
        SECS: begin
          state <= IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd      = step;
    cmd.load = start && !busy;
  end

  `ASSERT_NEXT(a_start_enters_diva, clk, rst, start && !busy, state == DIVA)
  `ASSERT_NEXT(a_last_step_frees, clk, rst, cmd.second, !busy && state == IDLE)
  `ASSERT_IMPL(a_one_step, clk, rst, 1'b1, $onehot0(cmd))
  `ASSERT_IMPL(a_busy_tracks_state, clk, rst, 1'b1, busy == (state != IDLE))

endmodule

/* rtl/ces_dp.sv */
module ces_dp
  import ces_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ces_cmd_t    cmd,
  input  logic [15:0] cal_year,
  input  logic [3:0]  cal_month,
  input  logic [4:0]  cal_day,
  input  logic [4:0]  cal_hour,
  input  logic [5:0]  cal_minute,
  input  logic [5:0]  cal_second,
  output logic        done,
  output logic [40:0] epoch_seconds
);

  logic [15:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [9:0]  q25_prev;
  logic [9:0]  q25_cur;
  logic [24:0] span365;
  logic [24:0] ydays;
  logic [40:0] acc;

  logic [15:0] year_m1;
  logic [15:0] span;
  logic [13:0] div_op;
  logic [26:0] div_prod;
  logic [9:0]  div_q;
  logic        after_epoch;
  logic        leap;
  logic [40:0] times60;

  assign year_m1     = year - 16'd1;
  assign span        = year - EpochYear;
  assign after_epoch = year > EpochYear;

  // Quarter of the year (or of the year before), divided by 25.
  assign div_op   = cmd.div_cur ? year[15:2] : year_m1[15:2];
  assign div_prod = 27'(div_op) * 27'(Recip25);
  assign div_q    = div_prod[Recip25Sh +: 10];

  // Divisible by 4; by 100 only when also by 400.
  assign leap = (year[1:0] == 2'd0) &&
                ((year[15:2] != (14'(q25_cur) * 14'd25)) || (q25_cur[1:0] == 2'd0));

  assign times60 = (acc << 6) - (acc << 2);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year   <= cal_year;
      month  <= cal_month;
      day    <= cal_day;
      hour   <= cal_hour;
      minute <= cal_minute;
      second <= cal_second;
    end
    if (cmd.div_prev) begin
      q25_prev <= div_q;
      span365  <= after_epoch ? 25'(span) * 25'd365 : '0;
    end
    if (cmd.div_cur) begin
      q25_cur <= div_q;
      // n/4 - n/100 + n/400 for n = year - 1, minus leaps before 1970
      ydays   <= after_epoch ?
                 span365 + 25'(year_m1[15:2]) - 25'(q25_prev) + 25'(q25_prev[9:2])
                 - LeapsBefore : '0;
    end
    if (cmd.days) begin
      acc <= 41'(ydays) + 41'(days_before_month(month))
             + 41'(leap && (month >= 4'd3)) + 41'(day) - 41'd1;
    end
    if (cmd.hour) begin
      acc <= (acc << 4) + (acc << 3) + 41'(hour);
    end
    if (cmd.minute) begin
      acc <= times60 + 41'(minute);
    end
    if (cmd.second) begin
      epoch_seconds <= times60 + 41'(second);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.second;
    end
  end

endmodule

/* rtl/calendar_to_epoch_seconds.sv */
// Calendar time to seconds since 1970-01-01 00:00:00 (Gregorian rules).
//
// Command channel: drive the six calendar fields with start high; the word
// is taken at the rising edge where start is high and busy is low. busy
// then stays high while the conversion runs.
// Result channel: done pulses for exactly one cycle with epoch_seconds
// valid in that cycle. The receiver cannot stall; the result is simply
// there for that one cycle and must be captured then.
// Steps: the accepted word makes two passes through the shared
// divide-by-25 multiplier (year and year minus one), a day summation,
// then three shift-add scale steps for hours, minutes and seconds; done
// is registered from the last of these. busy falls in the done cycle, so
// the next start is taken at the edge that ends it; a new word is not
// taken before the current one is done.
// Reset (rst, synchronous, active high) returns the controller to idle and
// drops any conversion in flight; no result is produced for it.
// Out-of-range fields are not checked; day zero steps back modulo 2^41.
`include "assert_macros.svh"

module calendar_to_epoch_seconds
  import ces_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] cal_year,
  input  logic [3:0]  cal_month,
  input  logic [4:0]  cal_day,
  input  logic [4:0]  cal_hour,
  input  logic [5:0]  cal_minute,
  input  logic [5:0]  cal_second,
  output logic        done,
  output logic [40:0] epoch_seconds
);

  // Step commands from the sequencer to the datapath.
  ces_cmd_t cmd;

  // Sequencer: one step per cycle, idle between words.
  ces_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath: capture the word, count days, scale to seconds.
  ces_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cal_year      (cal_year),
    .cal_month     (cal_month),
    .cal_day       (cal_day),
    .cal_hour      (cal_hour),
    .cal_minute    (cal_minute),
    .cal_second    (cal_second),
    .done          (done),
    .epoch_seconds (epoch_seconds)
  );

  // A result only appears once the sequencer has let go.
  `ASSERT_IMPL(a_done_when_free, clk, rst, done, !busy)

endmodule

/* tb/calendar_to_epoch_seconds_tb.sv */
`timescale 1ns / 100ps

module calendar_to_epoch_seconds_tb;

  // Days from 0001-01-01 up to the epoch year are never counted; the
  // predictor works relative to this year.
  localparam int unsigned BaseYear      = 1970;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned MaxReported   = 10;
  // Settle time after the last result, longer than one conversion takes.
  localparam int unsigned SettleCycles  = 12;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] cal_year = '0;
  logic [3:0]  cal_month = '0;
  logic [4:0]  cal_day = '0;
  logic [4:0]  cal_hour = '0;
  logic [5:0]  cal_minute = '0;
  logic [5:0]  cal_second = '0;
  logic        done;
  logic [40:0] epoch_seconds;

  // Seconds we still expect from the block, oldest first.
  logic [40:0] pending_seconds[$];
  logic [40:0] want_seconds;

  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned stray_results = 0;
  int unsigned quiet_cycles = 0;
  bit          idling_on = 1'b1;

  calendar_to_epoch_seconds dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cal_year     (cal_year),
    .cal_month    (cal_month),
    .cal_day      (cal_day),
    .cal_hour     (cal_hour),
    .cal_minute   (cal_minute),
    .cal_second   (cal_second),
    .done         (done),
    .epoch_seconds(epoch_seconds)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Calendar arithmetic
  // ---------------------------------------------------------------------

  function automatic bit is_leap(input longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Leap years among years 1 through n.
  function automatic longint unsigned leap_count(input longint unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  // Days in whole months ahead of month m in a common year; month zero
  // counts nothing, anything past December counts the full year.
  function automatic longint unsigned month_offset(input logic [3:0] m);
    case (m)
      4'd0, 4'd1: return 0;
      4'd2:       return 31;
      4'd3:       return 59;
      4'd4:       return 90;
      4'd5:       return 120;
      4'd6:       return 151;
      4'd7:       return 181;
      4'd8:       return 212;
      4'd9:       return 243;
      4'd10:      return 273;
      4'd11:      return 304;
      4'd12:      return 334;
      default:    return 365;
    endcase
  endfunction

  function automatic logic [40:0] epoch_of(input cal_word_t w);
    longint unsigned yr;
    longint unsigned days;
    longint unsigned secs;
    yr   = w.year;
    days = 0;
    // Years before the epoch add nothing, same as the epoch year itself.
    if (yr > BaseYear)
      days = (yr - BaseYear) * 365 + leap_count(yr - 1) - leap_count(BaseYear - 1);
    days += month_offset(w.month);
    if (w.month >= 4'd3 && is_leap(yr))
      days += 1;
    // Day zero goes one day back and wraps at the epoch itself.
    days = days + w.day - 1;
    secs = days * 24 + w.hour;
    secs = secs * 60 + w.minute;
    secs = secs * 60 + w.second;
    return secs[40:0];
  endfunction

  // ---------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------

  function automatic cal_word_t make_word(input int unsigned y, input int unsigned mo,
                                          input int unsigned d, input int unsigned h,
                                          input int unsigned mi, input int unsigned s);
    cal_word_t w;
    w.year   = y[15:0];
    w.month  = mo[3:0];
    w.day    = d[4:0];
    w.hour   = h[4:0];
    w.minute = mi[5:0];
    w.second = s[5:0];
    return w;
  endfunction

  // Plausible date: most years near the present, some from the epoch up to
  // 65535, some straddling century years where the leap rules bite.
  function automatic cal_word_t random_date();
    int unsigned pick;
    int unsigned y;
    pick = $urandom_range(0, 9);
    if (pick < 6)
      y = $urandom_range(BaseYear, 2400);
    else if (pick < 8)
      y = $urandom_range(BaseYear, 65535);
    else
      y = $urandom_range(20, 654) * 100 + $urandom_range(0, 2) - 1;
    return make_word(y, $urandom_range(1, 12), $urandom_range(1, 31),
                     $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
  endfunction

  // Every bit of every field free, out-of-range values included.
  function automatic cal_word_t random_raw();
    return make_word($urandom_range(0, 65535), $urandom_range(0, 15), $urandom_range(0, 31),
                     $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Present one word at the falling edge and hold it until the block
  // takes it. Start stays high on return so the next word can follow
  // without a gap.
  task automatic send_word(input cal_word_t w);
    @(negedge clk);
    start      <= 1'b1;
    cal_year   <= w.year;
    cal_month  <= w.month;
    cal_day    <= w.day;
    cal_hour   <= w.hour;
    cal_minute <= w.minute;
    cal_second <= w.second;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  // Drop start and scramble the fields while waiting, so a word
  // taken without start would show up as a stray result.
  task automatic hold_off(input int unsigned n);
    @(negedge clk);
    start      <= 1'b0;
    cal_year   <= $urandom_range(0, 65535);
    cal_month  <= $urandom_range(0, 15);
    cal_day    <= $urandom_range(0, 31);
    cal_hour   <= $urandom_range(0, 31);
    cal_minute <= $urandom_range(0, 63);
    cal_second <= $urandom_range(0, 63);
    repeat (n) @(posedge clk);
  endtask

  // Random burst gap after a word, when idling is on.
  task automatic maybe_gap();
    if (idling_on && $urandom_range(0, 3) == 0)
      hold_off($urandom_range(1, 13));
  endtask

  // Stop sending until every outstanding conversion has come back.
  task automatic drain_results();
    hold_off(1);
    while (pending_seconds.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done) begin
        if (pending_seconds.size() == 0) begin
          stray_results++;
          if (mismatches + stray_results <= MaxReported)
            $display("%0t: done with no word outstanding, epoch_seconds=%0d",
                     $realtime, epoch_seconds);
        end else begin
          want_seconds = pending_seconds.pop_front();
          results_checked++;
          if (epoch_seconds !== want_seconds) begin
            mismatches++;
            if (mismatches + stray_results <= MaxReported)
              $display("%0t: epoch_seconds mismatch: expected %0d, got %0d",
                       $realtime, want_seconds, epoch_seconds);
          end
        end
      end
      // Record the prediction at the edge that takes the word.
      if (start && !busy)
        pending_seconds.push_back(epoch_of(make_word(cal_year, cal_month, cal_day,
                                                     cal_hour, cal_minute, cal_second)));
      if (done || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("Watchdog: %0d cycles without progress, %0d results outstanding",
                 WatchdogLimit, pending_seconds.size());
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Field extremes and the out-of-range cases the block passes through.
  task automatic test_field_extremes();
    send_word(make_word(1970, 1, 1, 0, 0, 0));      // the epoch itself
    send_word(make_word(1970, 1, 0, 0, 0, 0));      // day zero at the epoch wraps
    send_word(make_word(1970, 1, 0, 0, 0, 1));
    send_word(make_word(0, 1, 1, 0, 0, 0));         // year below the epoch
    send_word(make_word(1969, 7, 4, 12, 30, 30));
    send_word(make_word(65535, 12, 31, 23, 59, 59));
    send_word(make_word(65535, 15, 31, 31, 63, 63)); // every field at its top
    send_word(make_word(2021, 0, 15, 6, 0, 0));     // month zero acts as January
    send_word(make_word(2021, 13, 1, 0, 0, 0));     // past December: whole year
    send_word(make_word(2020, 14, 1, 0, 0, 0));
    send_word(make_word(2038, 1, 19, 3, 14, 7));
    send_word(make_word(2000, 2, 31, 24, 60, 60));  // no carry checks at all
    send_word(make_word(1999, 12, 31, 23, 59, 59));
  endtask

  // Leap rules: every fourth year, not centuries, but every 400th.
  task automatic test_leap_rules();
    send_word(make_word(1972, 2, 29, 0, 0, 0));
    send_word(make_word(1972, 3, 1, 0, 0, 0));
    send_word(make_word(1900, 3, 1, 0, 0, 0));
    send_word(make_word(2000, 3, 1, 0, 0, 0));
    send_word(make_word(2024, 2, 29, 12, 0, 0));
    send_word(make_word(2024, 3, 1, 0, 0, 0));
    send_word(make_word(2100, 3, 1, 0, 0, 0));
    send_word(make_word(2400, 12, 31, 0, 0, 0));
    send_word(make_word(2401, 1, 1, 0, 0, 0));
    send_word(make_word(65200, 3, 1, 0, 0, 0));
    drain_results();
  endtask

  // Plausible dates in blocks, idling switched on and off between blocks.
  task automatic test_random_dates(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 150 == 0)
        idling_on = $urandom_range(0, 2) != 0;
      // Let the pipeline run dry once partway through.
      if (i == n / 2)
        drain_results();
      send_word(random_date());
      maybe_gap();
    end
  endtask

  task automatic test_random_raw_fields(input int unsigned n);
    idling_on = 1'b1;
    for (int unsigned i = 0; i < n; i++) begin
      send_word(random_raw());
      maybe_gap();
    end
  endtask

  // Final stretch: words back to back, no gaps.
  task automatic test_back_to_back(input int unsigned n);
    idling_on = 1'b0;
    for (int unsigned i = 0; i < n; i++)
      send_word($urandom_range(0, 3) == 0 ? random_raw() : random_date());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_leap_rules();
    test_random_dates(1100);
    test_random_raw_fields(400);
    test_back_to_back(300);

    // Drop start, wait out every outstanding result, then a few cycles
    // more so a late stray strobe is still caught.
    hold_off(1);
    while (pending_seconds.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d words; checked %0d conversions (%0d mismatches, %0d stray).",
             words_sent, results_checked, mismatches, stray_results);
    $display("Covered epoch and leap/century edges, out-of-range fields, gaps and bursts.");
    if (mismatches == 0 && stray_results == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
